// ===== hw/rtl/alcp_pkg.sv =====
`default_nettype none
package alcp_pkg;

  typedef logic [2:0] step_t;

  localparam step_t STEP_ACCEPT    = 3'd0;
  localparam step_t STEP_STRIP_RD  = 3'd1;
  localparam step_t STEP_STRIP_TST = 3'd2;
  localparam step_t STEP_SCAN_RD   = 3'd3;
  localparam step_t STEP_SCAN_TST  = 3'd4;
  localparam step_t STEP_PARSE     = 3'd5;
  localparam step_t STEP_EMIT      = 3'd6;

  typedef enum logic [2:0] {
    OP_ACCEPT,
    OP_STRIP_RD,
    OP_STRIP_TST,
    OP_SCAN_RD,
    OP_SCAN_TST,
    OP_PARSE,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    COND_LINE_END,
    COND_IDX_ZERO,
    COND_BLANK,
    COND_IDX_END,
    COND_RD_ZERO,
    COND_REPLY,
    COND_EMIT_LAST
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t tgt_taken;
    step_t tgt_not;
  } uword_t;

  typedef struct packed {
    logic line_end;
    logic idx_zero;
    logic blank;
    logic idx_end;
    logic rd_zero;
    logic reply;
    logic emit_last;
  } status_t;

  localparam logic [7:0]  CH_NUL     = 8'h00;
  localparam logic [7:0]  CH_TAB     = 8'h09;
  localparam logic [7:0]  CH_LF      = 8'h0A;
  localparam logic [7:0]  CH_CR      = 8'h0D;
  localparam logic [7:0]  CH_SPACE   = 8'h20;
  localparam logic [7:0]  CH_COLON   = 8'h3A;
  localparam logic [7:0]  OUT_MASK   = 8'h3F;
  localparam logic [31:0] CMD_OUT    = "OUT:";
  localparam logic [23:0] CMD_REQ    = "REQ";
  localparam logic [47:0] REPLY_HEAD = "STATE:";

  function automatic logic [7:0] hex_char(logic [3:0] d);
    if (d < 4'd10) begin
      hex_char = 8'h30 + {4'h0, d};
    end else begin
      hex_char = 8'h37 + {4'h0, d};
    end
  endfunction

  // {valid, value}
  function automatic logic [4:0] hex_val(logic [7:0] c);
    logic [7:0] t;
    t = 8'h00;
    hex_val = 5'h00;
    if (c inside {[8'h30:8'h39]}) begin
      t = c - 8'h30;
      hex_val = {1'b1, t[3:0]};
    end else if (c inside {[8'h41:8'h46]}) begin
      t = c - 8'h37;
      hex_val = {1'b1, t[3:0]};
    end else if (c inside {[8'h61:8'h66]}) begin
      t = c - 8'h57;
      hex_val = {1'b1, t[3:0]};
    end
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/alcp_in_if.sv =====
`default_nettype none
interface alcp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic [7:0] input_pins;

  modport source (output valid, output rx_byte, output input_pins, input ready);
  modport sink (input valid, input rx_byte, input input_pins, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/alcp_out_if.sv =====
`default_nettype none
interface alcp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] tx_byte;
  logic       last_of_reply;
  logic [5:0] output_pins;

  modport source (output valid, output tx_byte, output last_of_reply, output output_pins,
                  input ready);
  modport sink (input valid, input tx_byte, input last_of_reply, input output_pins,
                output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/alcp_sequencer.sv =====
`default_nettype none
module alcp_sequencer
  import alcp_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire status_t status,
  output op_t          op
);

  step_t  pc_r, pc_nxt;
  uword_t uw;
  logic   taken;

  function automatic uword_t ucode(step_t s);
    case (s)
      STEP_ACCEPT:    ucode = '{OP_ACCEPT,    COND_LINE_END,  STEP_STRIP_RD,  STEP_ACCEPT};
      STEP_STRIP_RD:  ucode = '{OP_STRIP_RD,  COND_IDX_ZERO,  STEP_ACCEPT,    STEP_STRIP_TST};
      STEP_STRIP_TST: ucode = '{OP_STRIP_TST, COND_BLANK,     STEP_STRIP_RD,  STEP_SCAN_RD};
      STEP_SCAN_RD:   ucode = '{OP_SCAN_RD,   COND_IDX_END,   STEP_PARSE,     STEP_SCAN_TST};
      STEP_SCAN_TST:  ucode = '{OP_SCAN_TST,  COND_RD_ZERO,   STEP_PARSE,     STEP_SCAN_RD};
      STEP_PARSE:     ucode = '{OP_PARSE,     COND_REPLY,     STEP_EMIT,      STEP_ACCEPT};
      STEP_EMIT:      ucode = '{OP_EMIT,      COND_EMIT_LAST, STEP_ACCEPT,    STEP_EMIT};
      default:        ucode = '{OP_ACCEPT,    COND_LINE_END,  STEP_STRIP_RD,  STEP_ACCEPT};
    endcase
  endfunction

  always_comb begin
    uw = ucode(pc_r);
  end

  always_comb begin
    case (uw.cond)
      COND_LINE_END:  taken = status.line_end;
      COND_IDX_ZERO:  taken = status.idx_zero;
      COND_BLANK:     taken = status.blank;
      COND_IDX_END:   taken = status.idx_end;
      COND_RD_ZERO:   taken = status.rd_zero;
      COND_REPLY:     taken = status.reply;
      COND_EMIT_LAST: taken = status.emit_last;
      default:        taken = 1'b0;
    endcase
    pc_nxt = taken ? uw.tgt_taken : uw.tgt_not;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= STEP_ACCEPT;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  assign op = uw.op;

endmodule
`default_nettype wire

// ===== hw/rtl/alcp_datapath.sv =====
`default_nettype none
module alcp_datapath
  import alcp_pkg::*;
#(
  parameter int LINE_BYTES = 32
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire op_t   op,
  output status_t    status,
  alcp_in_if.sink    in_if,
  alcp_out_if.source out_if
);

  localparam int IW = $clog2(LINE_BYTES);
  localparam logic [IW-1:0] LEN_MAX = IW'(LINE_BYTES - 1);

  logic [7:0]    mem [LINE_BYTES];
  logic [7:0]    ch_r [6];
  logic [IW-1:0] len_r, len_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [IW-1:0] end_r, end_nxt;
  logic [IW-1:0] rd_addr;
  logic [7:0]    rd_data_r;
  logic [7:0]    pins_r, pins_nxt;
  logic [5:0]    outreg_r, outreg_nxt;
  logic [3:0]    k_r, k_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [7:0]    tx_r, tx_nxt;
  logic          last_r, last_nxt;
  logic [5:0]    opins_r, opins_nxt;

  logic          acc, is_eol, wr_en, ch_en, load;
  logic          is_blank, is_zero;
  logic [4:0]    hv4, hv5;
  logic          is_out, out_ok, req_ok;
  logic [7:0]    v8, vm;
  logic          ph, oh;
  logic [3:0]    pn, on, j, j3;
  logic [47:0]   hd;
  logic [7:0]    reply_char;
  logic          is_last;

  assign in_if.ready = (op == OP_ACCEPT);
  assign acc         = in_if.valid && in_if.ready;
  assign is_eol      = (in_if.rx_byte == CH_LF) || (in_if.rx_byte == CH_CR);
  assign wr_en       = acc && !is_eol && (len_r < LEN_MAX);
  assign ch_en       = (op == OP_SCAN_TST) && (idx_r < IW'(6));
  assign rd_addr     = (op == OP_STRIP_RD) ? (idx_r - IW'(1)) : idx_r;
  assign is_blank    = (rd_data_r == CH_SPACE) || (rd_data_r == CH_TAB);
  assign is_zero     = (rd_data_r == CH_NUL);
  assign load        = (op == OP_EMIT) && (!out_valid_r || out_if.ready);

  // command decode over the captured head of the line
  always_comb begin
    hv4    = hex_val(ch_r[4]);
    hv5    = hex_val(ch_r[5]);
    is_out = (end_r >= IW'(4)) && ({ch_r[0], ch_r[1], ch_r[2], ch_r[3]} == CMD_OUT);
    out_ok = is_out && (end_r >= IW'(6)) && hv4[4];
    req_ok = (end_r == IW'(3)) && ({ch_r[0], ch_r[1], ch_r[2]} == CMD_REQ);
    v8     = hv5[4] ? {hv4[3:0], hv5[3:0]} : {4'h0, hv4[3:0]};
    vm     = v8 & OUT_MASK;
  end

  // reply character at position k_r
  always_comb begin
    ph         = (pins_r[7:4] != 4'h0);
    oh         = (outreg_r[5:4] != 2'b00);
    pn         = ph ? 4'd2 : 4'd1;
    on         = oh ? 4'd2 : 4'd1;
    hd         = REPLY_HEAD << {k_r[2:0], 3'b000};
    j          = k_r - 4'd6;
    j3         = j - pn - 4'd1;
    reply_char = CH_NUL;
    is_last    = 1'b0;
    if (k_r < 4'd6) begin
      reply_char = hd[47:40];
    end else if (j < pn) begin
      reply_char = hex_char((ph && (j == 4'd0)) ? pins_r[7:4] : pins_r[3:0]);
    end else if (j == pn) begin
      reply_char = CH_COLON;
    end else if (j3 < on) begin
      reply_char = hex_char((oh && (j3 == 4'd0)) ? {2'b00, outreg_r[5:4]} : outreg_r[3:0]);
    end else if (j3 == on) begin
      reply_char = CH_CR;
    end else begin
      reply_char = CH_LF;
      is_last    = 1'b1;
    end
  end

  always_comb begin
    status.line_end  = acc && is_eol && (len_r != '0);
    status.idx_zero  = (idx_r == '0);
    status.blank     = is_blank;
    status.idx_end   = (idx_r == end_r);
    status.rd_zero   = is_zero;
    status.reply     = out_ok || req_ok;
    status.emit_last = load && is_last;
  end

  always_comb begin
    len_nxt    = len_r;
    idx_nxt    = idx_r;
    end_nxt    = end_r;
    pins_nxt   = pins_r;
    outreg_nxt = outreg_r;
    k_nxt      = k_r;
    tx_nxt     = tx_r;
    last_nxt   = last_r;
    opins_nxt  = opins_r;
    case (op)
      OP_ACCEPT: begin
        if (acc) begin
          pins_nxt = in_if.input_pins;
          if (is_eol) begin
            if (len_r != '0) begin
              idx_nxt = len_r;
              len_nxt = '0;
            end
          end else if (len_r < LEN_MAX) begin
            len_nxt = len_r + IW'(1);
          end
        end
      end
      OP_STRIP_TST: begin
        if (is_blank) begin
          idx_nxt = idx_r - IW'(1);
        end else begin
          end_nxt = idx_r;
          idx_nxt = '0;
        end
      end
      OP_SCAN_TST: begin
        if (is_zero) begin
          end_nxt = idx_r;
        end else begin
          idx_nxt = idx_r + IW'(1);
        end
      end
      OP_PARSE: begin
        k_nxt = 4'd0;
        if (out_ok) begin
          outreg_nxt = vm[5:0];
        end
      end
      OP_EMIT: begin
        if (load) begin
          tx_nxt    = reply_char;
          last_nxt  = is_last;
          opins_nxt = outreg_r;
          k_nxt     = k_r + 4'd1;
        end
      end
      default: ;
    endcase
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[len_r] <= in_if.rx_byte;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (ch_en) begin
      ch_r[idx_r[2:0]] <= rd_data_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      outreg_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      len_r       <= len_nxt;
      outreg_r    <= outreg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r   <= idx_nxt;
    end_r   <= end_nxt;
    pins_r  <= pins_nxt;
    k_r     <= k_nxt;
    tx_r    <= tx_nxt;
    last_r  <= last_nxt;
    opins_r <= opins_nxt;
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.tx_byte       = tx_r;
  assign out_if.last_of_reply = last_r;
  assign out_if.output_pins   = opins_r;

endmodule
`default_nettype wire

// ===== hw/rtl/ascii_line_command_parser_top.sv =====
// Ordinary character: stored while the line has room, and the block stays ready for more input.
// CR or LF ending a non-empty line: accepted, trailing blanks stripped by reading back from
// the end, the line scanned up to a zero byte or its end, the command decoded, and on a
// valid command one reply byte per cycle into the output register while the output does not
// stall. The store has one registered read port.
// Reset clears line length, output register and the pending result; the store is not cleared.
`default_nettype none
module ascii_line_command_parser_top
  import alcp_pkg::*;
#(
  parameter int LINE_BYTES = 32
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  alcp_in_if.sink    in_if,
  alcp_out_if.source out_if
);

  op_t     op;
  status_t status;

  alcp_sequencer u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .op     (op)
  );

  alcp_datapath #(
    .LINE_BYTES (LINE_BYTES)
  ) u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .op     (op),
    .status (status),
    .in_if  (in_if),
    .out_if (out_if)
  );

endmodule
`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
`default_nettype none
module testbench
  import alcp_pkg::*;
();

  localparam int LINE_BYTES     = 32;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 2 * LINE_BYTES + 40;

  typedef struct packed {
    logic [7:0] tx;
    logic       last;
    logic [5:0] pins;
  } reply_beat_t;

  logic clk = 1'b0;
  logic rst_n;

  alcp_in_if  in_ch ();
  alcp_out_if out_ch ();

  ascii_line_command_parser_top #(
    .LINE_BYTES(LINE_BYTES)
  ) u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_ch),
    .out_if(out_ch)
  );

  reply_beat_t reply_q[$];
  logic [7:0]  line_buf[LINE_BYTES];
  int          line_cnt       = 0;
  logic [5:0]  out_model      = 6'h00;
  int          mismatch_count = 0;
  int          sent_items     = 0;
  int          idle_cycles    = 0;
  int          in_idle_pct;
  int          out_stall_pct;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int digit_value(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    return -1;
  endfunction

  function automatic logic [7:0] nibble_char(input logic [3:0] v);
    if (v < 4'd10) return 8'("0") + 8'(v);
    return 8'("A") + 8'(v) - 8'd10;
  endfunction

  task automatic queue_state_reply(input logic [7:0] pins);
    logic [7:0]  text[$];
    reply_beat_t beat;
    for (int k = 0; k < 6; k++) text.push_back(REPLY_HEAD[47 - 8 * k -: 8]);
    if (pins >= 8'h10) text.push_back(nibble_char(pins[7:4]));
    text.push_back(nibble_char(pins[3:0]));
    text.push_back(CH_COLON);
    if (out_model >= 6'h10) text.push_back(nibble_char({2'b00, out_model[5:4]}));
    text.push_back(nibble_char(out_model[3:0]));
    text.push_back(CH_CR);
    text.push_back(CH_LF);
    foreach (text[k]) begin
      beat.tx   = text[k];
      beat.last = (k == text.size() - 1);
      beat.pins = out_model;
      reply_q.push_back(beat);
    end
  endtask

  task automatic predict_byte(input logic [7:0] ch, input logic [7:0] pins);
    int len;
    int n;
    int d0;
    int d1;
    int v;
    if (ch == CH_LF || ch == CH_CR) begin
      if (line_cnt != 0) begin
        len = line_cnt;
        while (len > 0 && (line_buf[len - 1] == CH_SPACE || line_buf[len - 1] == CH_TAB))
          len--;
        line_cnt = 0;
        n = 0;
        while (n < len && line_buf[n] != CH_NUL) n++;
        len = n;
        if (len >= 4 && {line_buf[0], line_buf[1], line_buf[2], line_buf[3]} == CMD_OUT) begin
          d0 = (len >= 6) ? digit_value(line_buf[4]) : -1;
          if (d0 >= 0) begin
            d1 = digit_value(line_buf[5]);
            v = (d1 < 0) ? d0 : d0 * 16 + d1;
            v = v & int'(OUT_MASK);
            out_model = v[5:0];
            queue_state_reply(pins);
          end
        end else if (len == 3 && {line_buf[0], line_buf[1], line_buf[2]} == CMD_REQ) begin
          queue_state_reply(pins);
        end
      end
    end else if (line_cnt < LINE_BYTES - 1) begin
      line_buf[line_cnt] = ch;
      line_cnt++;
    end
  endtask

  task automatic report_mismatch(input string field, input int got, input int want);
    if (mismatch_count < 100) begin
      $display("%0t: mismatch on %s: got %0h, want %0h", $time, field, got, want);
    end
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    reply_beat_t want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) predict_byte(in_ch.rx_byte, in_ch.input_pins);
      if (out_ch.valid && out_ch.ready) begin
        if (reply_q.size() == 0) begin
          report_mismatch("unexpected tx_byte", out_ch.tx_byte, 0);
        end else begin
          want = reply_q.pop_front();
          if (out_ch.tx_byte !== want.tx) report_mismatch("tx_byte", out_ch.tx_byte, want.tx);
          if (out_ch.last_of_reply !== want.last)
            report_mismatch("last_of_reply", out_ch.last_of_reply, want.last);
          if (out_ch.output_pins !== want.pins)
            report_mismatch("output_pins", out_ch.output_pins, want.pins);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= ($urandom_range(99) >= out_stall_pct);
    end
  end

  task automatic send_byte(input logic [7:0] ch, input logic [7:0] pins);
    if ($urandom_range(99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < in_idle_pct);
    end
    in_ch.valid      <= 1'b1;
    in_ch.rx_byte    <= ch;
    in_ch.input_pins <= pins;
    // hold until the transaction completes
    do @(posedge clk); while (!in_ch.ready);
    sent_items++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], 8'($urandom_range(255)));
  endtask

  task automatic send_blanks(input int n);
    repeat (n) send_byte($urandom_range(1) ? CH_SPACE : CH_TAB, 8'($urandom_range(255)));
  endtask

  task automatic end_line();
    send_byte($urandom_range(1) ? CH_CR : CH_LF, 8'($urandom_range(255)));
  endtask

  function automatic logic [7:0] rand_hex_char();
    int v;
    v = $urandom_range(15);
    if (v < 10) return 8'("0") + 8'(v);
    return ($urandom_range(1) ? 8'("A") : 8'("a")) + 8'(v - 10);
  endfunction

  function automatic logic [7:0] rand_non_hex();
    string pool;
    pool = "GgxZ!-:/~q";
    return pool[$urandom_range(pool.len() - 1)];
  endfunction

  function automatic logic [7:0] rand_printable();
    return 8'($urandom_range(8'h7E, 8'h21));
  endfunction

  task automatic send_random_line();
    int kind;
    int n;
    kind = $urandom_range(99);
    if (kind < 35) begin
      send_text("REQ");
      send_blanks($urandom_range(3));
      end_line();
    end else if (kind < 70) begin
      send_text("OUT:");
      send_byte(rand_hex_char(), 8'($urandom_range(255)));
      if ($urandom_range(3) != 0) begin
        send_byte(rand_hex_char(), 8'($urandom_range(255)));
      end else begin
        send_byte(rand_non_hex(), 8'($urandom_range(255)));
      end
      n = $urandom_range(3);
      repeat (n) send_byte(rand_printable(), 8'($urandom_range(255)));
      send_blanks($urandom_range(2));
      end_line();
    end else if (kind < 80) begin
      case ($urandom_range(4))
        0: begin
          send_text("OUT:");
          n = $urandom_range(1);
          repeat (n) send_byte(rand_hex_char(), 8'($urandom_range(255)));
        end
        1: begin
          send_text("OUT:");
          send_byte(rand_non_hex(), 8'($urandom_range(255)));
          send_byte(rand_hex_char(), 8'($urandom_range(255)));
        end
        2: begin
          send_text("REQ");
          send_byte(rand_printable(), 8'($urandom_range(255)));
        end
        3: begin
          send_text("REQ");
          send_byte(CH_NUL, 8'($urandom_range(255)));
          send_byte(rand_printable(), 8'($urandom_range(255)));
        end
        default: begin
          send_text("OUT:");
          send_byte(rand_hex_char(), 8'($urandom_range(255)));
          send_byte(CH_NUL, 8'($urandom_range(255)));
          send_byte(rand_hex_char(), 8'($urandom_range(255)));
        end
      endcase
      send_blanks($urandom_range(2));
      end_line();
    end else if (kind < 90) begin
      if ($urandom_range(1)) begin
        send_text("REQ");
        send_blanks($urandom_range(34, 26));
      end else begin
        send_text("OUT:");
        send_byte(rand_hex_char(), 8'($urandom_range(255)));
        send_byte(rand_hex_char(), 8'($urandom_range(255)));
      end
      n = $urandom_range(40, 20);
      repeat (n) send_byte(rand_printable(), 8'($urandom_range(255)));
      end_line();
    end else begin
      n = $urandom_range(8, 1);
      repeat (n) send_byte(8'($urandom_range(255)), 8'($urandom_range(255)));
    end
  endtask

  task automatic test_request_reply();
    send_text("REQ");
    send_byte(CH_CR, 8'h00);
    send_text("REQ");
    send_byte(CH_LF, 8'hFF);
    send_text("REQ");
    send_byte(CH_CR, 8'h0F);
    send_text("REQ");
    send_byte(CH_LF, 8'h10);
  endtask

  task automatic test_output_load();
    send_text("OUT:3F");
    send_byte(CH_CR, 8'hA5);
    send_text("OUT:ff");
    send_byte(CH_LF, 8'h5A);
    send_text("OUT:40");
    send_byte(CH_CR, 8'h01);
    send_text("OUT:Bc");
    send_byte(CH_LF, 8'hFE);
    send_text("OUT:7x");
    send_byte(CH_CR, 8'h80);
    send_text("OUT:00");
    send_byte(CH_LF, 8'h7F);
  endtask

  task automatic test_rejected_lines();
    send_text("OUT:1A");
    send_byte(CH_CR, 8'h33);
    send_text("OUT:");
    send_byte(CH_CR, 8'h00);
    send_text("OUT:5");
    send_byte(CH_LF, 8'h00);
    send_text("OUT:g1");
    send_byte(CH_CR, 8'h00);
    send_text("REQX");
    send_byte(CH_LF, 8'h00);
    send_text("req");
    send_byte(CH_CR, 8'h00);
    send_byte(CH_CR, 8'h00);
    send_text(" \t ");
    send_byte(CH_LF, 8'h00);
    send_text("REQ");
    send_byte(CH_CR, 8'hC3);
  endtask

  task automatic test_line_limits();
    send_text("REQ \t \t");
    send_byte(CH_CR, 8'h42);
    send_text("REQ");
    send_byte(CH_NUL, 8'h00);
    send_text("x");
    send_byte(CH_LF, 8'h24);
    send_text("OUT:4");
    send_byte(CH_NUL, 8'h00);
    send_text("1");
    send_byte(CH_CR, 8'h00);
    send_text("REQ");
    repeat (LINE_BYTES - 4) send_byte(CH_SPACE, 8'h00);
    send_text("X");
    send_byte(CH_CR, 8'hE7);
    send_text("OUT:2A");
    repeat (40) send_byte("z", 8'h00);
    send_byte(CH_LF, 8'h99);
    send_byte(CH_CR, 8'h00);
  endtask

  task automatic test_random_traffic(input int in_pct, input int out_pct, input int count);
    int target;
    in_idle_pct   = in_pct;
    out_stall_pct = out_pct;
    target = sent_items + count;
    while (sent_items < target) send_random_line();
  endtask

  initial begin
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.rx_byte    = 8'h00;
    in_ch.input_pins = 8'h00;
    in_idle_pct      = 6;
    out_stall_pct    = 85;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_request_reply();
    test_output_load();
    test_rejected_lines();
    test_line_limits();
    test_random_traffic(6, 85, 6);
    test_random_traffic(85, 6, 6);
    test_random_traffic(0, 0, 6);
    in_ch.valid <= 1'b0;
    while (reply_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && reply_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
